// ===== hdl/tmb_pkg.sv =====
package tmb_pkg;

	// Field widths fixed by the port list
	localparam int FUNC_W = 2;
	localparam int ID_W   = 4;
	localparam int TMO_W  = 32;
	localparam int WAIT_W = 31;

	// Command codes on func
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

	// Result kinds
	localparam logic KIND_EXPIRY  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Saturation limit of next_wait, held wide for the compare
	localparam logic [63:0] WAIT_MAX = 64'h0000_0000_7FFF_FFFF;

	// One result transaction handed from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [ID_W-1:0]   fired_id;
		logic [WAIT_W-1:0] next_wait;
		logic              none_active;
		logic              last;
	} emit_t;

endpackage

// ===== hdl/tmb_alu.sv =====
module tmb_alu #(
	parameter int TIME_BITS = 32
) (
	input  logic [TIME_BITS-1:0] a,
	input  logic [TIME_BITS-1:0] b,
	input  logic                 sub,
	input  logic [TIME_BITS-1:0] ca,
	input  logic [TIME_BITS-1:0] cb,
	output logic [TIME_BITS-1:0] sum,
	output logic                 le
);

	logic [TIME_BITS-1:0] b_eff;

	// Add or subtract, wrapping modulo 2^TIME_BITS
	assign b_eff = sub ? ~b : b;
	assign sum   = a + b_eff + TIME_BITS'(sub);

	// Unsigned less-or-equal compare
	assign le = (ca <= cb);

endmodule

// ===== hdl/tmb_store.sv =====
module tmb_store #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32,
	parameter int IDX_W      = 4
) (
	input  logic                 clk,
	input  logic                 wr_all,
	input  logic                 wr_dl,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [TIME_BITS-1:0] wr_deadline,
	input  logic [TIME_BITS-1:0] wr_period,
	input  logic                 wr_periodic,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [TIME_BITS-1:0] rd_deadline,
	output logic [TIME_BITS-1:0] rd_period,
	output logic                 rd_periodic
);

	logic [TIME_BITS-1:0] deadline_mem [NUM_TIMERS];
	logic [TIME_BITS-1:0] period_mem   [NUM_TIMERS];
	logic                 periodic_mem [NUM_TIMERS];

	// Write a whole entry on start, only the deadline on a periodic reload
	always_ff @(posedge clk) begin
		if (wr_all || wr_dl) begin
			deadline_mem[wr_addr] <= wr_deadline;
		end
		if (wr_all) begin
			period_mem[wr_addr]   <= wr_period;
			periodic_mem[wr_addr] <= wr_periodic;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_deadline <= deadline_mem[rd_addr];
		rd_period   <= period_mem[rd_addr];
		rd_periodic <= periodic_mem[rd_addr];
	end

endmodule

// ===== hdl/tmb_seq.sv =====
module tmb_seq #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tmb_pkg::FUNC_W-1:0] func,
	input  logic [tmb_pkg::ID_W-1:0]   slot,
	input  logic [tmb_pkg::TMO_W-1:0]  timeout,
	input  logic                       repeat_req,
	input  logic                       out_free,
	output logic                       busy,
	output tmb_pkg::emit_t             emit
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [TIME_BITS-1:0] SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TICK = 6'b000010,
		ST_EVAL = 6'b000100,
		ST_UPD  = 6'b001000,
		ST_MINC = 6'b010000,
		ST_SUM  = 6'b100000
	} state_t;

	state_t                state_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  nxt_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  found_q;
	logic [TIME_BITS-1:0]  best_q;
	logic                  fire_q;
	logic                  perio_q;
	logic                  live_q;
	logic [TIME_BITS-1:0]  d_q;
	logic [TIME_BITS-1:0]  per_q;
	logic [TIME_BITS-1:0]  sum_q;
	logic [TIME_BITS-1:0]  newd_q;

	logic [TIME_BITS-1:0] alu_a;
	logic [TIME_BITS-1:0] alu_b;
	logic                 alu_sub;
	logic [TIME_BITS-1:0] alu_ca;
	logic [TIME_BITS-1:0] alu_cb;
	logic [TIME_BITS-1:0] alu_sum;
	logic                 alu_le;

	logic                 wr_all;
	logic                 wr_dl;
	logic [IDX_W-1:0]     wr_addr;
	logic [TIME_BITS-1:0] wr_deadline;
	logic [IDX_W-1:0]     rd_addr;
	logic [TIME_BITS-1:0] rd_deadline;
	logic [TIME_BITS-1:0] rd_period;
	logic                 rd_periodic;

	logic [63:0]          tmo_wide;
	logic [TIME_BITS-1:0] tmo;
	logic [IDX_W-1:0]     sid;
	logic                 id_ok;
	logic                 accept;
	logic                 idx_last;
	logic [IDX_W-1:0]     idx_nxt;
	logic                 cur_armed;
	logic [TIME_BITS-1:0] upd_deadline;
	logic                 better;
	logic                 minc_go;
	logic [TIME_BITS-1:0] diff;
	logic [63:0]          diff_wide;
	logic [tmb_pkg::WAIT_W-1:0] wait_val;

	// Decode the command
	assign tmo_wide = 64'(timeout);
	assign tmo      = tmo_wide[TIME_BITS-1:0];
	assign sid      = IDX_W'(slot);
	assign id_ok    = (32'(slot) < 32'(NUM_TIMERS));
	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign busy     = (state_q != ST_IDLE);

	// Scan index stepping
	assign idx_last  = (idx_q == IDX_W'(NUM_TIMERS - 1));
	assign idx_nxt   = idx_last ? '0 : idx_q + IDX_W'(1);
	assign cur_armed = armed_q[idx_q];

	// Steer the shared adder and comparator by state
	always_comb begin
		alu_a   = now_q;
		alu_b   = tmo;
		alu_sub = 1'b0;
		alu_ca  = sum_q;
		alu_cb  = now_q;
		case (state_q)
			ST_IDLE: begin
				alu_a = now_q;
				alu_b = tmo;
			end
			ST_TICK: begin
				alu_a = nxt_q;
				alu_b = TIME_BITS'(1);
			end
			ST_EVAL: begin
				alu_a  = rd_deadline;
				alu_b  = rd_period;
				alu_ca = rd_deadline;
				alu_cb = nxt_q;
			end
			ST_UPD: begin
				alu_a  = now_q;
				alu_b  = per_q;
				alu_ca = sum_q;
				alu_cb = now_q;
			end
			ST_MINC: begin
				alu_a   = newd_q;
				alu_b   = now_q;
				alu_sub = 1'b1;
				alu_ca  = best_q;
				alu_cb  = alu_sum ^ SIGN;
			end
			default: begin
				alu_a = now_q;
				alu_b = tmo;
			end
		endcase
	end

	tmb_alu #(
		.TIME_BITS(TIME_BITS)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sub(alu_sub),
		.ca (alu_ca),
		.cb (alu_cb),
		.sum(alu_sum),
		.le (alu_le)
	);

	// Reload a fired periodic timer; restart at now+period if it fell behind
	always_comb begin
		upd_deadline = d_q;
		if (fire_q && perio_q) begin
			upd_deadline = alu_le ? alu_sum : sum_q;
		end
	end

	// Memory port steering
	assign wr_all      = accept && (func == tmb_pkg::FUNC_START) && id_ok;
	assign wr_dl       = (state_q == ST_UPD) && fire_q && perio_q;
	assign wr_addr     = (state_q == ST_IDLE) ? sid : idx_q;
	assign wr_deadline = (state_q == ST_IDLE) ? alu_sum : upd_deadline;
	assign rd_addr     = (state_q == ST_TICK) ? '0 : idx_nxt;

	tmb_store #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk        (clk),
		.wr_all     (wr_all),
		.wr_dl      (wr_dl),
		.wr_addr    (wr_addr),
		.wr_deadline(wr_deadline),
		.wr_period  (tmo),
		.wr_periodic(repeat_req),
		.rd_addr    (rd_addr),
		.rd_deadline(rd_deadline),
		.rd_period  (rd_period),
		.rd_periodic(rd_periodic)
	);

	// Running minimum over sign-flipped remaining times
	assign better  = !found_q || !alu_le;
	assign minc_go = !fire_q || out_free;

	// Clamp the summary wait to 1 .. 2^31-1
	assign diff      = best_q ^ SIGN;
	assign diff_wide = 64'(diff);
	always_comb begin
		if (diff[TIME_BITS-1] || (diff == '0)) begin
			wait_val = tmb_pkg::WAIT_W'(1);
		end else if (diff_wide > tmb_pkg::WAIT_MAX) begin
			wait_val = tmb_pkg::WAIT_MAX[tmb_pkg::WAIT_W-1:0];
		end else begin
			wait_val = diff_wide[tmb_pkg::WAIT_W-1:0];
		end
	end

	// Build the result transaction
	always_comb begin
		emit             = '0;
		emit.kind        = tmb_pkg::KIND_EXPIRY;
		emit.fired_id    = tmb_pkg::ID_W'(idx_q);
		if ((state_q == ST_MINC) && fire_q && out_free) begin
			emit.valid = 1'b1;
		end else if ((state_q == ST_SUM) && out_free) begin
			emit.valid       = 1'b1;
			emit.kind        = tmb_pkg::KIND_SUMMARY;
			emit.fired_id    = '0;
			emit.next_wait   = found_q ? wait_val : '0;
			emit.none_active = !found_q;
			emit.last        = 1'b1;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			nxt_q   <= TIME_BITS'(1);
			armed_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == tmb_pkg::FUNC_START && id_ok) begin
							armed_q[sid] <= 1'b1;
						end else if (func == tmb_pkg::FUNC_STOP && id_ok) begin
							armed_q[sid] <= 1'b0;
						end else if (func == tmb_pkg::FUNC_TICK) begin
							state_q <= ST_TICK;
						end
					end
				end
				ST_TICK: begin
					now_q   <= nxt_q;
					nxt_q   <= alu_sum;
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (cur_armed) begin
						state_q <= ST_UPD;
					end else if (idx_last) begin
						state_q <= ST_SUM;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				ST_UPD: begin
					if (fire_q && !perio_q) begin
						armed_q[idx_q] <= 1'b0;
					end
					state_q <= ST_MINC;
				end
				ST_MINC: begin
					if (minc_go) begin
						if (live_q && better) begin
							found_q <= 1'b1;
						end
						if (idx_last) begin
							state_q <= ST_SUM;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-entry working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			fire_q  <= alu_le;
			sum_q   <= alu_sum;
			d_q     <= rd_deadline;
			per_q   <= rd_period;
			perio_q <= rd_periodic;
		end
		if (state_q == ST_UPD) begin
			newd_q <= upd_deadline;
			live_q <= !(fire_q && !perio_q);
		end
		if ((state_q == ST_MINC) && minc_go && live_q && better) begin
			best_q <= alu_sum ^ SIGN;
		end
	end

endmodule

// ===== hdl/multi_channel_timer_bank.sv =====
// Channel  Direction  Handshake           Payload
// in       receive    in_valid/in_stall   func, slot, timeout, repeat_req
// out      send       out_valid/out_stall kind, fired_id, next_wait, none_active, last
//
// Start, stop and unused codes complete on acceptance. A tick steps through a
// tick state, an evaluate state per timer, update and minimum states per armed
// timer, then a summary state; the single read port of the timer memory and the
// one shared adder/comparator set that sequence. Output stalls can hold the scan.
// arst_n clears the tick counter and the armed bits; timer memory is not cleared.
// in_stall is high from an accepted tick until its summary enters the output register.
module multi_channel_timer_bank #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tmb_pkg::FUNC_W-1:0] func,
	input  logic [tmb_pkg::ID_W-1:0]   slot,
	input  logic [tmb_pkg::TMO_W-1:0]  timeout,
	input  logic                       repeat_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [tmb_pkg::ID_W-1:0]   fired_id,
	output logic [tmb_pkg::WAIT_W-1:0] next_wait,
	output logic                       none_active,
	output logic                       last
);

	logic           busy;
	logic           out_free;
	tmb_pkg::emit_t emit;
	logic           out_valid_q;
	tmb_pkg::emit_t out_q;

	assign in_stall = busy;
	assign out_free = !out_valid_q || !out_stall;

	tmb_seq #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_BITS (TIME_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.slot      (slot),
		.timeout   (timeout),
		.repeat_req(repeat_req),
		.out_free  (out_free),
		.busy      (busy),
		.emit      (emit)
	);

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_q <= emit;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign fired_id    = out_q.fired_id;
	assign next_wait   = out_q.next_wait;
	assign none_active = out_q.none_active;
	assign last        = out_q.last;

	// Never load the output register over a result that is still held
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("result loaded while output register busy");

	// A tick transaction makes the block busy on the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == tmb_pkg::FUNC_TICK) |=> in_stall)
		else $error("tick accepted without starting a scan");

	// Start, stop and unused-code transactions leave the block free on the next cycle and produce no result
	a_cmd_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func != tmb_pkg::FUNC_TICK) |=> (!in_stall && !emit.valid))
		else $error("start or stop left the block busy");

endmodule

// ===== tb/tb.sv =====
module tb;

	localparam logic [tmb_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int NUM_IDS       = 16;
	localparam int RANDOM_ITEMS  = 480;
	localparam int STUCK_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 60;

	// One command transaction waiting for the driver
	typedef struct {
		logic [tmb_pkg::FUNC_W-1:0] func;
		logic [tmb_pkg::ID_W-1:0]   slot;
		logic [tmb_pkg::TMO_W-1:0]  timeout;
		logic                       repeat_req;
		logic                       drain_first;
	} timer_cmd_t;

	// One expected output transaction
	typedef struct packed {
		logic                       kind;
		logic [tmb_pkg::ID_W-1:0]   fired_id;
		logic [tmb_pkg::WAIT_W-1:0] next_wait;
		logic                       none_active;
		logic                       last;
	} timer_event_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [tmb_pkg::FUNC_W-1:0] func = '0;
	logic [tmb_pkg::ID_W-1:0]   slot = '0;
	logic [tmb_pkg::TMO_W-1:0]  timeout = '0;
	logic                       repeat_req = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       kind;
	logic [tmb_pkg::ID_W-1:0]   fired_id;
	logic [tmb_pkg::WAIT_W-1:0] next_wait;
	logic                       none_active;
	logic                       last;

	timer_cmd_t   pending_cmds[$];
	timer_event_t timer_events_due[$];

	// Shadow copy of the timer bank
	logic [31:0] now_ticks;
	logic        armed_q[NUM_IDS];
	logic [31:0] deadline_q[NUM_IDS];
	logic [31:0] period_q[NUM_IDS];
	logic        periodic_q[NUM_IDS];

	int          total_cmds = 0;
	int          cmds_accepted = 0;
	int          stuck_cycles = 0;
	int          mismatches = 0;
	logic        timed_out = 1'b0;
	timer_cmd_t  next_cmd;
	logic        send_now;
	timer_event_t got_event;
	timer_event_t want_event;

	multi_channel_timer_bank u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.slot        (slot),
		.timeout     (timeout),
		.repeat_req  (repeat_req),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.fired_id    (fired_id),
		.next_wait   (next_wait),
		.none_active (none_active),
		.last        (last)
	);

	// Idle percentage per side for the current third of the run
	function automatic int idle_pct(input logic receiver);
		int phase;
		begin
			phase = (total_cmds == 0) ? 0 : (cmds_accepted * 3) / total_cmds;
			case (phase)
				0: idle_pct = receiver ? 88 : 24;
				1: idle_pct = receiver ? 24 : 88;
				default: idle_pct = 0;
			endcase
		end
	endfunction

	task automatic queue_cmd(input logic [tmb_pkg::FUNC_W-1:0] f,
			input logic [tmb_pkg::ID_W-1:0] id, input logic [tmb_pkg::TMO_W-1:0] tmo,
			input logic rep, input logic drain);
		timer_cmd_t c;
		begin
			c.func        = f;
			c.slot        = id;
			c.timeout     = tmo;
			c.repeat_req  = rep;
			c.drain_first = drain;
			pending_cmds.push_back(c);
		end
	endtask

	// Apply one accepted command to the shadow bank and queue what it emits
	task automatic predict_timer_events(input timer_cmd_t c);
		timer_event_t ev;
		logic [31:0]        due_edge;
		logic signed [31:0] remain;
		logic signed [31:0] best;
		logic               found;
		int                 i;
		begin
			case (c.func)
				tmb_pkg::FUNC_START: begin
					armed_q[c.slot]    = 1'b1;
					deadline_q[c.slot] = now_ticks + c.timeout;
					period_q[c.slot]   = c.timeout;
					periodic_q[c.slot] = c.repeat_req;
				end
				tmb_pkg::FUNC_STOP: begin
					armed_q[c.slot] = 1'b0;
				end
				tmb_pkg::FUNC_TICK: begin
					now_ticks = now_ticks + 32'd1;
					due_edge  = now_ticks + 32'd1;
					// scan in id order, report each expiry
					for (i = 0; i < NUM_IDS; i++) begin
						if (armed_q[i] && deadline_q[i] <= due_edge) begin
							if (periodic_q[i]) begin
								deadline_q[i] = deadline_q[i] + period_q[i];
								if (deadline_q[i] <= now_ticks)
									deadline_q[i] = now_ticks + period_q[i];
							end else begin
								armed_q[i] = 1'b0;
							end
							ev.kind        = tmb_pkg::KIND_EXPIRY;
							ev.fired_id    = i[tmb_pkg::ID_W-1:0];
							ev.next_wait   = '0;
							ev.none_active = 1'b0;
							ev.last        = 1'b0;
							timer_events_due.push_back(ev);
						end
					end
					// find the nearest deadline as a signed distance
					found = 1'b0;
					best  = '0;
					for (i = 0; i < NUM_IDS; i++) begin
						if (armed_q[i]) begin
							remain = $signed(deadline_q[i] - now_ticks);
							if (!found || remain < best)
								best = remain;
							found = 1'b1;
						end
					end
					ev.kind        = tmb_pkg::KIND_SUMMARY;
					ev.fired_id    = '0;
					ev.none_active = !found;
					ev.last        = 1'b1;
					if (!found)
						ev.next_wait = '0;
					else if (best < 1)
						ev.next_wait = 31'd1;
					else
						ev.next_wait = best[tmb_pkg::WAIT_W-1:0];
					timer_events_due.push_back(ev);
				end
				default: ;
			endcase
		end
	endtask

	// Clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Driver: hand out queued commands, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			func       <= '0;
			slot       <= '0;
			timeout    <= '0;
			repeat_req <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				next_cmd.func        = func;
				next_cmd.slot        = slot;
				next_cmd.timeout     = timeout;
				next_cmd.repeat_req  = repeat_req;
				next_cmd.drain_first = 1'b0;
				predict_timer_events(next_cmd);
				cmds_accepted = cmds_accepted + 1;
			end
			send_now = 1'b0;
			if (pending_cmds.size() > 0) begin
				// hold a marked command until every result is out
				if (pending_cmds[0].drain_first && timer_events_due.size() != 0)
					send_now = 1'b0;
				else
					send_now = ($urandom_range(99) >= idle_pct(1'b0));
			end
			if (send_now) begin
				next_cmd = pending_cmds.pop_front();
				func       <= next_cmd.func;
				slot       <= next_cmd.slot;
				timeout    <= next_cmd.timeout;
				repeat_req <= next_cmd.repeat_req;
			end
			in_valid <= send_now;
		end
	end

	// Monitor: random stall, compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b1;
			stuck_cycles <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct(1'b1));
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (out_valid && !out_stall) begin
				got_event.kind        = kind;
				got_event.fired_id    = fired_id;
				got_event.next_wait   = next_wait;
				got_event.none_active = none_active;
				got_event.last        = last;
				if (timer_events_due.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result: kind=%0d id=%0d wait=%0d none=%0d last=%0d",
							kind, fired_id, next_wait, none_active, last);
				end else begin
					want_event = timer_events_due.pop_front();
					if (got_event.kind !== want_event.kind ||
							got_event.fired_id !== want_event.fired_id ||
							got_event.next_wait !== want_event.next_wait ||
							got_event.none_active !== want_event.none_active ||
							got_event.last !== want_event.last) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10) begin
							$write("mismatch: exp kind=%0d id=%0d wait=%0d none=%0d last=%0d, ",
								want_event.kind, want_event.fired_id, want_event.next_wait,
								want_event.none_active, want_event.last);
							$display("got kind=%0d id=%0d wait=%0d none=%0d last=%0d",
								kind, fired_id, next_wait, none_active, last);
						end
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int    i;
		int    n;
		int    pick;
		logic [tmb_pkg::TMO_W-1:0] tmo;

		now_ticks = '0;
		for (i = 0; i < NUM_IDS; i++) begin
			armed_q[i]    = 1'b0;
			deadline_q[i] = '0;
			period_q[i]   = '0;
			periodic_q[i] = 1'b0;
		end

		// directed: empty bank, zero timeout, extreme timeouts, restart, ignored code
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd15, 32'hFFFF_FFFF,  1'b1, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd1,  32'd1,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd2,  32'd0,          1'b1, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd3,  32'h7FFF_FFFF,  1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd4,  32'h8000_0000,  1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(FUNC_UNUSED,         4'd15, 32'hFFFF_FFFF,  1'b1, 1'b0);
		queue_cmd(tmb_pkg::FUNC_STOP,  4'd2,  32'hFFFF_FFFF,  1'b1, 1'b1);
		queue_cmd(tmb_pkg::FUNC_STOP,  4'd15, 32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd2,  32'd2,          1'b1, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd2,  32'd5,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_START, 4'd9,  32'hFFFF_FFFF,  1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_STOP,  4'd3,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_STOP,  4'd4,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_STOP,  4'd5,  32'd0,          1'b0, 1'b0);
		queue_cmd(tmb_pkg::FUNC_TICK,  4'd0,  32'd0,          1'b0, 1'b0);

		// random: mostly short timeouts so timers fire, some wide ones and noise
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			case ($urandom_range(9))
				0: tmo = $urandom();
				1: tmo = 32'h7FFF_FFF0 + $urandom_range(31);
				2: tmo = 32'hFFFF_FFF0 + $urandom_range(15);
				default: tmo = $urandom_range(24);
			endcase
			if (pick < 45) begin
				queue_cmd(tmb_pkg::FUNC_TICK, tmb_pkg::ID_W'($urandom()), $urandom(),
					1'($urandom()), $urandom_range(39) == 0);
				n++;
			end else if (pick < 77) begin
				queue_cmd(tmb_pkg::FUNC_START, tmb_pkg::ID_W'($urandom()), tmo,
					1'($urandom()), 1'b0);
				n++;
			end else if (pick < 95) begin
				queue_cmd(tmb_pkg::FUNC_STOP, tmb_pkg::ID_W'($urandom()), $urandom(),
					1'($urandom()), 1'b0);
				n++;
			end else begin
				queue_cmd(FUNC_UNUSED, tmb_pkg::ID_W'($urandom()), $urandom(),
					1'($urandom()), 1'b0);
			end
		end
		total_cmds = pending_cmds.size();

		// reset
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all commands and results, or a stuck block
		while (!timed_out && !(cmds_accepted == total_cmds && timer_events_due.size() == 0)) begin
			@(negedge clk);
			if (stuck_cycles >= STUCK_LIMIT)
				timed_out = 1'b1;
		end

		if (timed_out) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (mismatches == 0 && timer_events_due.size() == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tmb_pkg.sv
hdl/tmb_alu.sv
hdl/tmb_store.sv
hdl/tmb_seq.sv
hdl/multi_channel_timer_bank.sv
tb/tb.sv
